/* design/framed_command_responder_unit_macros.svh */
`ifndef FRAMED_COMMAND_RESPONDER_UNIT_MACROS_SVH
`define FRAMED_COMMAND_RESPONDER_UNIT_MACROS_SVH

// Invariant checked at every edge outside reset.
`define FCR_ASSERT_ALWAYS(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

// Same-cycle implication.
`define FCR_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

`endif

/* design/fcr_pkg.sv */
package fcr_pkg;

  localparam int MAX_PAYLOAD = 16;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_PAYLOAD);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // status answer payload is the longest one
  localparam int ANSWER_MAX = 10;
  localparam int IDX_W      = $clog2(ANSWER_MAX + 2);
  localparam int PL_IDX_W   = $clog2(ANSWER_MAX);

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [6:0]        POWER_MAX    = 7'd100;
  localparam logic [6:0]        LIMIT_RESET  = 7'd100;
  localparam logic [6:0]        POWER_RESET  = 7'd0;
  localparam logic signed [15:0] TARGET_RESET = 16'sd50;

  localparam logic [7:0] SYNC_RESET      = 8'd170;
  localparam logic [7:0] ACK_RESET       = 8'd6;
  localparam logic [7:0] NAK_RESET       = 8'd21;
  localparam logic [7:0] GET_RESET       = 8'd1;
  localparam logic [7:0] SET_TEMP_RESET  = 8'd2;
  localparam logic [7:0] SET_POWER_RESET = 8'd3;
  localparam logic [7:0] SET_LIMIT_RESET = 8'd4;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_ABORT = 1'b1;

  typedef enum logic [2:0] {
    REG_SYNC      = 3'd0,
    REG_ACK       = 3'd1,
    REG_NAK       = 3'd2,
    REG_GET       = 3'd3,
    REG_SET_TEMP  = 3'd4,
    REG_SET_POWER = 3'd5,
    REG_SET_LIMIT = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_GET   = 2'd0,
    CMD_TEMP  = 2'd1,
    CMD_POWER = 2'd2,
    CMD_LIMIT = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] sync_code;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
    logic [7:0] get_code;
    logic [7:0] set_temp_code;
    logic [7:0] set_power_code;
    logic [7:0] set_limit_code;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        has_one;
    logic        has_two;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [15:0] temp;
    logic [15:0] volt;
    logic [15:0] fan;
  } cmd_desc_t;

endpackage

/* design/fcr_req_if.sv */
interface fcr_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [7:0]         rx_byte;
  logic signed [15:0] temperature_tenths;
  logic [15:0]        supply_voltage;
  logic [15:0]        fan_current;

  modport source (
    output valid, opcode, rx_byte, temperature_tenths, supply_voltage, fan_current,
    input  ready
  );
  modport sink (
    input  valid, opcode, rx_byte, temperature_tenths, supply_voltage, fan_current,
    output ready
  );
endinterface

/* design/fcr_rsp_if.sv */
interface fcr_rsp_if;
  logic               valid;
  logic               ready;
  logic [7:0]         tx_byte;
  logic               last_byte;
  logic signed [15:0] target_tenths;
  logic [6:0]         power_percent;
  logic [6:0]         limit_percent;

  modport source (
    output valid, tx_byte, last_byte, target_tenths, power_percent, limit_percent,
    input  ready
  );
  modport sink (
    input  valid, tx_byte, last_byte, target_tenths, power_percent, limit_percent,
    output ready
  );
endinterface

/* design/fcr_front.sv */
`include "framed_command_responder_unit_macros.svh"

module fcr_front (
  input  logic              clk,
  input  logic              rst,
  input  fcr_pkg::cfg_t     cfg,
  fcr_req_if.sink           req,
  input  logic              q_full,
  output logic              push,
  output fcr_pkg::cmd_desc_t push_data
);
  import fcr_pkg::*;

  typedef enum logic [4:0] {
    PH_HUNT  = 5'b00001,
    PH_CMD   = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_t;

  phase_t           phase;
  logic [7:0]       command_code;
  logic [LEN_W-1:0] payload_length;
  logic [LEN_W-1:0] bytes_seen;
  logic [LEN_W-1:0] bytes_seen_next;
  logic [7:0]       running_xor;
  logic [7:0]       first_payload;
  logic [7:0]       second_payload;

  logic       accept;
  logic [7:0] b;
  logic       known;
  cmd_kind_t  kind;

  assign req.ready       = !q_full;
  assign accept          = req.valid && req.ready;
  assign b               = req.rx_byte;
  assign bytes_seen_next = LEN_W'(bytes_seen + 1'b1);

  // first match wins when codes collide
  always_comb begin
    known = 1'b1;
    kind  = CMD_GET;
    if (command_code == cfg.get_code) begin
      kind = CMD_GET;
    end else if (command_code == cfg.set_temp_code) begin
      kind = CMD_TEMP;
    end else if (command_code == cfg.set_power_code) begin
      kind = CMD_POWER;
    end else if (command_code == cfg.set_limit_code) begin
      kind = CMD_LIMIT;
    end else begin
      known = 1'b0;
    end
  end

  assign push = accept && (req.opcode == OP_BYTE) && (phase == PH_CHECK)
                && (b == running_xor) && known;

  always_comb begin
    push_data.kind    = kind;
    push_data.has_one = (payload_length != '0);
    push_data.has_two = (payload_length >= LEN_W'(2));
    push_data.first   = first_payload;
    push_data.second  = second_payload;
    push_data.temp    = req.temperature_tenths;
    push_data.volt    = req.supply_voltage;
    push_data.fan     = req.fan_current;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else if (accept) begin
      if (req.opcode == OP_ABORT) begin
        phase <= PH_HUNT;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (b == cfg.sync_code) begin
              running_xor <= b;
              phase       <= PH_CMD;
            end
          end
          PH_CMD: begin
            command_code <= b;
            running_xor  <= running_xor ^ b;
            phase        <= PH_LEN;
          end
          PH_LEN: begin
            if (b > MAX_LEN_BYTE) begin
              phase <= PH_HUNT;
            end else begin
              payload_length <= b[LEN_W-1:0];
              running_xor    <= running_xor ^ b;
              bytes_seen     <= '0;
              phase          <= (b == 8'd0) ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            if (bytes_seen == LEN_W'(0)) begin
              first_payload <= b;
            end else if (bytes_seen == LEN_W'(1)) begin
              second_payload <= b;
            end
            running_xor <= running_xor ^ b;
            bytes_seen  <= bytes_seen_next;
            if (bytes_seen_next >= payload_length) begin
              phase <= PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase <= PH_HUNT;
          end
          default: begin
            phase <= PH_HUNT;
          end
        endcase
      end
    end
  end

  `FCR_ASSERT_IMPLY(a_data_count, clk, rst, phase == PH_DATA, bytes_seen < payload_length, "payload count past length")

endmodule

/* design/fcr_queue.sv */
`include "framed_command_responder_unit_macros.svh"

module fcr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fcr_pkg::cmd_desc_t push_data,
  input  logic               pop,
  output fcr_pkg::cmd_desc_t pop_data,
  output logic               full,
  output logic               empty
);
  import fcr_pkg::*;

  cmd_desc_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

  `FCR_ASSERT_IMPLY(a_no_overflow, clk, rst, push, !full, "push into full queue")
  `FCR_ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !empty, "pop from empty queue")

endmodule

/* design/fcr_back.sv */
`include "framed_command_responder_unit_macros.svh"

module fcr_back (
  input  logic               clk,
  input  logic               rst,
  input  fcr_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  fcr_pkg::cmd_desc_t q_data,
  output logic               pop,
  fcr_rsp_if.source          rsp
);
  import fcr_pkg::*;

  // stored settings
  logic signed [15:0] target_temp;
  logic [6:0]         power_level;
  logic [6:0]         power_limit;

  // answer being sent
  logic               busy;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   ans_len;
  logic [7:0]         pl [ANSWER_MAX];
  logic [7:0]         chk;

  // output register
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;
  logic signed [15:0] out_target;
  logic [6:0]         out_power;
  logic [6:0]         out_limit;

  logic             load;
  logic             is_last;
  logic [IDX_W-1:0] idx_m1;
  logic [7:0]       byte_now;
  logic             ok;
  logic [6:0]       val7;

  assign pop     = !busy && !q_empty;
  assign load    = busy && (!out_valid || rsp.ready);
  assign idx_m1  = IDX_W'(idx - 1'b1);
  assign is_last = (idx == IDX_W'(ans_len + 1'b1));
  assign val7    = q_data.first[6:0];

  always_comb begin
    if (idx == '0) begin
      byte_now = 8'(ans_len);
    end else if (is_last) begin
      byte_now = chk;
    end else begin
      byte_now = pl[idx_m1[PL_IDX_W-1:0]];
    end
  end

  always_comb begin
    case (q_data.kind)
      CMD_TEMP:  ok = q_data.has_two;
      CMD_POWER: ok = q_data.has_one && (q_data.first <= 8'(POWER_MAX));
      CMD_LIMIT: ok = q_data.has_one && (q_data.first <= 8'(POWER_MAX));
      default:   ok = 1'b0;
    endcase
  end

  assign rsp.valid         = out_valid;
  assign rsp.tx_byte       = out_byte;
  assign rsp.last_byte     = out_last;
  assign rsp.target_tenths = out_target;
  assign rsp.power_percent = out_power;
  assign rsp.limit_percent = out_limit;

  // answer payload; set commands use only the first slot
  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_data.kind == CMD_GET) begin
        pl[0] <= q_data.temp[7:0];
        pl[1] <= q_data.temp[15:8];
        pl[2] <= target_temp[7:0];
        pl[3] <= target_temp[15:8];
        pl[4] <= q_data.volt[7:0];
        pl[5] <= q_data.volt[15:8];
        pl[6] <= q_data.fan[7:0];
        pl[7] <= q_data.fan[15:8];
        pl[8] <= {1'b0, power_level};
        pl[9] <= {1'b0, power_limit};
        ans_len <= IDX_W'(ANSWER_MAX);
      end else begin
        pl[0]   <= ok ? cfg.ack_code : cfg.nak_code;
        ans_len <= IDX_W'(1);
      end
    end
    if (load) begin
      out_byte   <= byte_now;
      out_last   <= is_last;
      out_target <= target_temp;
      out_power  <= power_level;
      out_limit  <= power_limit;
      chk        <= (idx == '0) ? byte_now : (chk ^ byte_now);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      idx         <= '0;
      out_valid   <= 1'b0;
      target_temp <= TARGET_RESET;
      power_level <= POWER_RESET;
      power_limit <= LIMIT_RESET;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
        case (q_data.kind)
          CMD_TEMP: begin
            if (ok) begin
              target_temp <= {q_data.second, q_data.first};
            end
          end
          CMD_POWER: begin
            if (ok && (val7 <= power_limit)) begin
              power_level <= val7;
            end
          end
          CMD_LIMIT: begin
            if (ok) begin
              power_limit <= val7;
              if (power_level > val7) begin
                power_level <= val7;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
        idx       <= IDX_W'(idx + 1'b1);
        if (is_last) begin
          busy <= 1'b0;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FCR_ASSERT_ALWAYS(a_power_in_limit, clk, rst, power_level <= power_limit, "power above limit")
  `FCR_ASSERT_ALWAYS(a_limit_range, clk, rst, power_limit <= POWER_MAX, "limit above 100")
  `FCR_ASSERT_IMPLY(a_idx_range, clk, rst, busy, idx <= IDX_W'(ans_len + 1'b1), "answer index overrun")

endmodule

/* design/framed_command_responder_unit.sv */
// Framed command responder.
// req channel: one word per received line byte (opcode 0) or a receive abort
//   (opcode 1), with the live temperature, voltage and fan readings alongside.
//   Frames are SYNC, CMD, LEN, PAYLOAD, CHECK (XOR of all previous bytes).
// rsp channel: answer words, LEN, PAYLOAD, CHECK; last_byte marks CHECK and each
//   word carries the stored target, power and limit after the command ran.
// The front parser takes one req word per cycle while the two-entry command
//   queue has room; a good frame pushes a command on its check byte.
// The back end pops a command, then sends one answer word per cycle, while
//   rsp.ready holds, through an output register: 3 words for an ACK/NAK
//   answer and 12 for the status answer. When the back end is idle, a
//   command pushed on its check byte is popped from the queue and its first
//   answer word is then loaded into the output register.
// A stalled rsp holds the back end; the front keeps taking bytes until the
//   queue fills, then drops req.ready.
// Reset (rst, synchronous) returns the parser to sync hunt, empties the queue,
//   sets target 50, power 0, limit 100 and all codes to their defaults.
// APB registers at 4*i: sync, ack, nak, get, set target, set power, set limit.
module framed_command_responder_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fcr_pkg::ADDR_W-1:0] paddr,
  input  logic [fcr_pkg::DATA_W-1:0] pwdata,
  output logic [fcr_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  fcr_req_if.sink                   req,
  fcr_rsp_if.source                 rsp
);
  import fcr_pkg::*;

  cfg_t      cfg;
  reg_idx_t  reg_idx;
  logic      wr_en;
  logic [7:0] rd_val;

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  cmd_desc_t q_in;
  cmd_desc_t q_out;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  // config write; unmapped addresses are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_code      <= SYNC_RESET;
      cfg.ack_code       <= ACK_RESET;
      cfg.nak_code       <= NAK_RESET;
      cfg.get_code       <= GET_RESET;
      cfg.set_temp_code  <= SET_TEMP_RESET;
      cfg.set_power_code <= SET_POWER_RESET;
      cfg.set_limit_code <= SET_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SYNC:      cfg.sync_code      <= pwdata[7:0];
        REG_ACK:       cfg.ack_code       <= pwdata[7:0];
        REG_NAK:       cfg.nak_code       <= pwdata[7:0];
        REG_GET:       cfg.get_code       <= pwdata[7:0];
        REG_SET_TEMP:  cfg.set_temp_code  <= pwdata[7:0];
        REG_SET_POWER: cfg.set_power_code <= pwdata[7:0];
        REG_SET_LIMIT: cfg.set_limit_code <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SYNC:      rd_val = cfg.sync_code;
      REG_ACK:       rd_val = cfg.ack_code;
      REG_NAK:       rd_val = cfg.nak_code;
      REG_GET:       rd_val = cfg.get_code;
      REG_SET_TEMP:  rd_val = cfg.set_temp_code;
      REG_SET_POWER: rd_val = cfg.set_power_code;
      REG_SET_LIMIT: rd_val = cfg.set_limit_code;
      default:       rd_val = 8'd0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

  // parser and classifier
  fcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  // decouples parsing from answer streaming
  fcr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // command execution and answer sender
  fcr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_out),
    .pop     (q_pop),
    .rsp     (rsp)
  );

endmodule
